FILE: rtl/calendar_date_stepper_unit_macros.svh
// ----------------------------------------------------------------------------
// calendar date stepper assertion macros
// shared concurrent assertion forms, clocked on clk, off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef CALENDAR_DATE_STEPPER_UNIT_MACROS_SVH
`define CALENDAR_DATE_STEPPER_UNIT_MACROS_SVH

// property that must hold in the same cycle as its trigger
`define CDS_ASSERT_SAME(label, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (prop)) \
    else $error(msg);

// property that must hold in the cycle after its trigger
`define CDS_ASSERT_NEXT(label, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
    else $error(msg);

`endif

FILE: rtl/cds_pkg.sv
// ----------------------------------------------------------------------------
// cds_pkg
// types, constants and calendar helpers for the calendar date stepper
// ----------------------------------------------------------------------------
package cds_pkg;

  localparam int unsigned CDS_FIFO_DEPTH = 2;

  // multiplicative inverse of 25 modulo 2^16, and the largest multiple-of-25 quotient
  localparam logic [15:0] INV25_16  = 16'h5C29;
  localparam logic [15:0] DIV25_MAX = 16'd2621;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_STEP = 2'd1,
    OP_CMP  = 2'd2,
    OP_NOP  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ORD_EQ      = 2'd0,
    ORD_EARLIER = 2'd1,
    ORD_LATER   = 2'd2
  } ord_t;

  typedef enum logic {
    BK_IDLE,
    BK_STEP
  } back_state_t;

  // classified command as it travels from front to back
  typedef struct packed {
    op_t         op;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
    logic        leap;
    logic        load_ok;
    logic        back;
    logic [15:0] count;
  } cmd_t;

  function automatic logic leap_fn(input logic [15:0] y);
    logic [15:0] prod;
    logic        div25;
    begin
      // exact divisibility by 25 through the odd inverse
      prod  = y * INV25_16;
      div25 = (prod <= DIV25_MAX);
      leap_fn = (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
    end
  endfunction

  function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
    begin
      unique case (m)
        4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: days_in = 5'd31;
        4'd4, 4'd6, 4'd9, 4'd11:                    days_in = 5'd30;
        4'd2:                                       days_in = leap ? 5'd29 : 5'd28;
        default:                                    days_in = 5'd0;
      endcase
    end
  endfunction

endpackage

FILE: rtl/cds_front.sv
// ----------------------------------------------------------------------------
// cds_front
// takes input transactions, registers them and classifies them into commands
// ----------------------------------------------------------------------------
module cds_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_command,
  input  logic [4:0]         in_day_in,
  input  logic [3:0]         in_month_in,
  input  logic [15:0]        in_year_in,
  input  logic signed [15:0] in_delta_days,
  output logic               push,
  output cds_pkg::cmd_t      push_data,
  input  logic               full
);
  import cds_pkg::*;

  logic        fr_v_r;
  logic [1:0]  fr_cmd_r;
  logic [4:0]  fr_day_r;
  logic [3:0]  fr_month_r;
  logic [15:0] fr_year_r;
  logic [15:0] fr_delta_r;
  logic        fr_leap_r;
  logic        take;
  logic        date_ok;

  assign in_stall = fr_v_r && full;
  assign push     = fr_v_r && !full;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_v_r <= 1'b0;
    end else if (take) begin
      fr_v_r <= 1'b1;
    end else if (push) begin
      fr_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fr_cmd_r   <= in_command;
      fr_day_r   <= in_day_in;
      fr_month_r <= in_month_in;
      fr_year_r  <= in_year_in;
      fr_delta_r <= in_delta_days;
      fr_leap_r  <= leap_fn(in_year_in);
    end
  end

  assign date_ok = (fr_month_r >= 4'd1) && (fr_month_r <= 4'd12) && (fr_day_r != 5'd0) &&
                   (fr_day_r <= days_in(fr_month_r, fr_leap_r));

  always_comb begin
    push_data.op      = op_t'(fr_cmd_r);
    push_data.day     = fr_day_r;
    push_data.month   = fr_month_r;
    push_data.year    = fr_year_r;
    push_data.leap    = fr_leap_r;
    push_data.load_ok = date_ok;
    push_data.back    = fr_delta_r[15];
    // magnitude of a negative delta, -32768 gives 32768
    push_data.count   = fr_delta_r[15] ? (16'd0 - fr_delta_r) : fr_delta_r;
  end

endmodule

FILE: rtl/cds_fifo.sv
// ----------------------------------------------------------------------------
// cds_fifo
// short command queue between the front and the back
// ----------------------------------------------------------------------------
`include "calendar_date_stepper_unit_macros.svh"

module cds_fifo #(
  parameter int unsigned DEPTH = cds_pkg::CDS_FIFO_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  cds_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output cds_pkg::cmd_t pop_data,
  output logic          empty
);
  import cds_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full     = (count_r == FULL_CNT);
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `CDS_ASSERT_SAME(a_fifo_count_bound, 1'b1, count_r <= FULL_CNT, "fifo count above depth")
  `CDS_ASSERT_SAME(a_fifo_no_overflow, push, !full, "push into full fifo")
  `CDS_ASSERT_SAME(a_fifo_no_underflow, pop, !empty, "pop from empty fifo")

endmodule

FILE: rtl/cds_back.sv
// ----------------------------------------------------------------------------
// cds_back
// holds the stored date, executes commands and steps one day per cycle
// ----------------------------------------------------------------------------
`include "calendar_date_stepper_unit_macros.svh"

module cds_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          empty,
  input  cds_pkg::cmd_t head,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [4:0]    out_cur_day,
  output logic [3:0]    out_cur_month,
  output logic [15:0]   out_cur_year,
  output logic          out_load_ok,
  output logic [1:0]    out_order_code,
  output logic          out_bound_hit
);
  import cds_pkg::*;

  back_state_t state_r, state_nxt;
  logic [4:0]  day_r, day_nxt;
  logic [3:0]  month_r, month_nxt;
  logic [15:0] year_r, year_nxt;
  logic        leap_r, leap_nxt;
  logic [15:0] count_r, count_nxt;
  logic        back_r, back_nxt;
  logic        bound_r, bound_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [4:0]  out_day_r, out_day_nxt;
  logic [3:0]  out_month_r, out_month_nxt;
  logic [15:0] out_year_r, out_year_nxt;
  logic        out_ok_r, out_ok_nxt;
  ord_t        out_ord_r, out_ord_nxt;
  logic        out_bound_r, out_bound_nxt;

  logic        out_free;
  logic        emit;
  logic        emit_ok;
  ord_t        emit_ord;
  logic        emit_bound;
  logic [4:0]  dim_cur;
  logic [4:0]  dim_prev;
  logic [24:0] stored_key;
  logic [24:0] given_key;

  assign out_free   = !out_valid_r || !out_stall;
  assign dim_cur    = days_in(month_r, leap_r);
  assign dim_prev   = days_in(month_r - 4'd1, leap_r);
  assign stored_key = {year_r, month_r, day_r};
  assign given_key  = {head.year, head.month, head.day};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      day_r       <= '0;
      month_r     <= '0;
      year_r      <= '0;
      leap_r      <= 1'b1;
      count_r     <= '0;
      back_r      <= 1'b0;
      bound_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      day_r       <= day_nxt;
      month_r     <= month_nxt;
      year_r      <= year_nxt;
      leap_r      <= leap_nxt;
      count_r     <= count_nxt;
      back_r      <= back_nxt;
      bound_r     <= bound_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_day_r   <= out_day_nxt;
    out_month_r <= out_month_nxt;
    out_year_r  <= out_year_nxt;
    out_ok_r    <= out_ok_nxt;
    out_ord_r   <= out_ord_nxt;
    out_bound_r <= out_bound_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    day_nxt       = day_r;
    month_nxt     = month_r;
    year_nxt      = year_r;
    // follows the year through a register, so it lags a year roll; a roll lands on jan 1 or dec 31 where it is unused
    leap_nxt      = leap_fn(year_r);
    count_nxt     = count_r;
    back_nxt      = back_r;
    bound_nxt     = bound_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_day_nxt   = out_day_r;
    out_month_nxt = out_month_r;
    out_year_nxt  = out_year_r;
    out_ok_nxt    = out_ok_r;
    out_ord_nxt   = out_ord_r;
    out_bound_nxt = out_bound_r;
    pop           = 1'b0;
    emit          = 1'b0;
    emit_ok       = 1'b0;
    emit_ord      = ORD_EQ;
    emit_bound    = 1'b0;

    unique case (state_r)
      BK_IDLE: begin
        if (!empty && ((head.op == OP_STEP) || out_free)) begin
          pop = 1'b1;
          unique case (head.op)
            OP_LOAD: begin
              emit    = 1'b1;
              emit_ok = head.load_ok;
              if (head.load_ok) begin
                day_nxt   = head.day;
                month_nxt = head.month;
                year_nxt  = head.year;
                leap_nxt  = head.leap;
              end else begin
                day_nxt   = '0;
                month_nxt = '0;
                year_nxt  = '0;
                leap_nxt  = 1'b1;
              end
            end
            OP_STEP: begin
              count_nxt = head.count;
              back_nxt  = head.back;
              bound_nxt = 1'b0;
              state_nxt = BK_STEP;
            end
            OP_CMP: begin
              emit = 1'b1;
              if (stored_key == given_key) begin
                emit_ord = ORD_EQ;
              end else if (stored_key < given_key) begin
                emit_ord = ORD_EARLIER;
              end else begin
                emit_ord = ORD_LATER;
              end
            end
            OP_NOP: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      BK_STEP: begin
        if (count_r == 16'd0) begin
          if (out_free) begin
            emit       = 1'b1;
            emit_bound = bound_r;
            state_nxt  = BK_IDLE;
          end
        end else if (!back_r) begin
          if (day_r >= dim_cur) begin
            if (month_r >= 4'd12) begin
              if (year_r == 16'hFFFF) begin
                bound_nxt = 1'b1;
                count_nxt = '0;
              end else begin
                year_nxt  = year_r + 16'd1;
                month_nxt = 4'd1;
                day_nxt   = 5'd1;
                count_nxt = count_r - 16'd1;
              end
            end else begin
              month_nxt = month_r + 4'd1;
              day_nxt   = 5'd1;
              count_nxt = count_r - 16'd1;
            end
          end else begin
            day_nxt   = day_r + 5'd1;
            count_nxt = count_r - 16'd1;
          end
        end else begin
          if (day_r <= 5'd1) begin
            if (month_r <= 4'd1) begin
              if (year_r == 16'd0) begin
                bound_nxt = 1'b1;
                count_nxt = '0;
              end else begin
                year_nxt  = year_r - 16'd1;
                month_nxt = 4'd12;
                day_nxt   = 5'd31;
                count_nxt = count_r - 16'd1;
              end
            end else begin
              month_nxt = month_r - 4'd1;
              day_nxt   = dim_prev;
              count_nxt = count_r - 16'd1;
            end
          end else begin
            day_nxt   = day_r - 5'd1;
            count_nxt = count_r - 16'd1;
          end
        end
      end
    endcase

    if (emit) begin
      out_valid_nxt = 1'b1;
      out_day_nxt   = day_nxt;
      out_month_nxt = month_nxt;
      out_year_nxt  = year_nxt;
      out_ok_nxt    = emit_ok;
      out_ord_nxt   = emit_ord;
      out_bound_nxt = emit_bound;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cur_day    = out_day_r;
  assign out_cur_month  = out_month_r;
  assign out_cur_year   = out_year_r;
  assign out_load_ok    = out_ok_r;
  assign out_order_code = out_ord_r;
  assign out_bound_hit  = out_bound_r;

  `CDS_ASSERT_SAME(a_month_range, 1'b1, month_r <= 4'd12, "stored month out of range")
  `CDS_ASSERT_SAME(a_no_pop_stepping, state_r == BK_STEP, !pop, "pop while stepping")
  `CDS_ASSERT_NEXT(a_count_walks, (state_r == BK_STEP) && (count_r != 16'd0),
                   (count_r == $past(count_r) - 16'd1) || (count_r == 16'd0), "step count skipped")

endmodule

FILE: rtl/calendar_date_stepper_unit.sv
// ----------------------------------------------------------------------------
// calendar_date_stepper_unit
// gregorian date register with load, day step and compare commands
// ----------------------------------------------------------------------------
// channel  | direction | handshake         | payload
// in_      | input     | in_valid/in_stall | command, day, month, year, delta
// out_     | output    | out_valid/out_stall | stored date and status flags
//
// load, compare and no-op are executed when popped; a step enters the day walk loop
// in the back end, which moves one day per cycle.
// a result passes the front register, the queue and the result register.
// synchronous active-low reset returns the stored date to 0/0/0 and empties the queue.
// a stalled result holds loads, compares, no-ops and the end of a step; a step is still
// popped and walked, and the front keeps taking transactions until the queue fills.
// ----------------------------------------------------------------------------
module calendar_date_stepper_unit #(
  parameter int unsigned FIFO_DEPTH = cds_pkg::CDS_FIFO_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_command,
  input  logic [4:0]         in_day_in,
  input  logic [3:0]         in_month_in,
  input  logic [15:0]        in_year_in,
  input  logic signed [15:0] in_delta_days,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [4:0]         out_cur_day,
  output logic [3:0]         out_cur_month,
  output logic [15:0]        out_cur_year,
  output logic               out_load_ok,
  output logic [1:0]         out_order_code,
  output logic               out_bound_hit
);
  import cds_pkg::*;

  logic push;
  cmd_t push_data;
  logic full;
  logic pop;
  cmd_t head;
  logic empty;

  cds_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_day_in     (in_day_in),
    .in_month_in   (in_month_in),
    .in_year_in    (in_year_in),
    .in_delta_days (in_delta_days),
    .push          (push),
    .push_data     (push_data),
    .full          (full)
  );

  cds_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (head),
    .empty     (empty)
  );

  cds_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .empty          (empty),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_cur_day    (out_cur_day),
    .out_cur_month  (out_cur_month),
    .out_cur_year   (out_cur_year),
    .out_load_ok    (out_load_ok),
    .out_order_code (out_order_code),
    .out_bound_hit  (out_bound_hit)
  );

endmodule
